// ===== rtl/core/ordered_sequence_table_assert.svh =====
// Assertion macros shared by the ordered sequence table RTL.
// Include this header inside module bodies that carry concurrent checks.
`ifndef ORDERED_SEQUENCE_TABLE_ASSERT_SVH
`define ORDERED_SEQUENCE_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside of reset.
`define OST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside of reset.
`define OST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ost_pkg.sv =====
// Package for the ordered sequence table: operation codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package ost_pkg;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int POS_W          = 7;
    localparam int VAL_W          = 32;

    typedef enum logic [KIND_W-1:0] {
        OP_INSERT_AT  = 3'd0,
        OP_SORTED_INS = 3'd1,
        OP_ERASE_AT   = 3'd2,
        OP_REMOVE_ALL = 3'd3,
        OP_GET        = 3'd4,
        OP_SET        = 3'd5,
        OP_FIND       = 3'd6,
        OP_NOP        = 3'd7
    } t_op;

    // Per-cell command broadcast by the controller.
    typedef enum logic [2:0] {
        CC_HOLD,
        CC_SHIFT_UP,
        CC_SHIFT_DOWN,
        CC_WRITE,
        CC_COMPACT
    } t_cell_cmd;
endpackage

// ===== rtl/core/ordered_sequence_table.sv =====
// Ordered sequence table: a fixed-capacity list held in a chain of entry cells.
// A request is accepted in S_IDLE, searched in S_SEARCH and applied in
// S_UPDATE, and its result is registered; a new request is taken only once the
// last one has been applied. Remove-all replaces the update step with a
// compaction pass in S_COMPACT over the stored entries, because the shared
// scan path moves one entry per cycle. Results wait in an output register: a
// new request is accepted while one waits, but its search holds until the
// waiting result has been taken. Depends on ost_pkg and the assertion header.
`timescale 1ns / 1ps

module ordered_sequence_table #(
    parameter int CAPACITY   = ost_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ost_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: position [6:0], item_value [38:7], zero fill [39]
    input  logic [39:0] s_axis_tdata,
    // tuser: kind [2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: ok [0], result_position [7:1], read_value [39:8],
    // removed_count [46:40], item_count [53:47], is_empty [54], zero fill [55]
    output logic [55:0] m_axis_tdata
);
    import ost_pkg::*;
    `include "ordered_sequence_table_assert.svh"

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE, S_COMPACT} t_state;

    t_state                r_state;
    t_op                   r_op;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_scan;
    logic [CNT_W-1:0]      r_wr;
    logic [CNT_W-1:0]      r_fpos;
    logic                  r_ok;
    logic [POS_W-1:0]      r_rpos;
    logic [VAL_W-1:0]      r_rval;
    logic [POS_W-1:0]      r_rcnt;
    logic                  r_tvalid;

    logic                  n_ok;
    logic [POS_W-1:0]      n_rpos;
    logic [VAL_W-1:0]      n_rval;
    logic [CNT_W-1:0]      n_fpos;

    t_cell_cmd             w_cmd;
    logic [IDX_W-1:0]      w_cell_pos;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]   w_eq;
    logic [CAPACITY-1:0]   w_ge;
    logic [CNT_W-1:0]      w_first_eq;
    logic [CNT_W-1:0]      w_first_ge;
    logic                  w_any_eq;
    logic [CNT_W-1:0]      w_pos_ext;
    logic [DATA_WIDTH-1:0] w_scan_data;
    logic                  w_out_free;

    assign w_pos_ext   = CNT_W'(r_pos);
    assign w_scan_data = w_data[r_scan[IDX_W-1:0]];
    assign w_out_free  = !r_tvalid || m_axis_tready;

    // Per-cell compare flags, masked to occupied entries.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_eq[k] = (CNT_W'(k) < r_count) && (w_data[k] == r_val);
            w_ge[k] = (CNT_W'(k) < r_count) && (w_data[k] >= r_val);
        end
    end

    // Priority search for the first equal and first greater-or-equal entry.
    always_comb begin
        w_first_eq = '0;
        w_first_ge = r_count;
        w_any_eq   = 1'b0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_eq[k]) begin
                w_first_eq = CNT_W'(k);
                w_any_eq   = 1'b1;
            end
            if (w_ge[k]) w_first_ge = CNT_W'(k);
        end
    end

    // Outcome of the search cycle for the held request.
    always_comb begin
        n_ok   = 1'b0;
        n_rpos = '0;
        n_rval = '0;
        n_fpos = w_pos_ext;
        unique case (r_op)
            OP_INSERT_AT: begin
                n_ok = (r_count < CNT_W'(CAPACITY)) && (r_pos <= POS_W'(r_count));
                if (n_ok) n_rpos = r_pos;
            end
            OP_SORTED_INS: begin
                n_ok   = r_count < CNT_W'(CAPACITY);
                n_fpos = w_first_ge;
                if (n_ok) n_rpos = POS_W'(w_first_ge);
            end
            OP_ERASE_AT, OP_SET: n_ok = r_pos < POS_W'(r_count);
            OP_GET: begin
                n_ok = r_pos < POS_W'(r_count);
                if (n_ok) n_rval = VAL_W'(w_data[r_pos[IDX_W-1:0]]);
            end
            OP_FIND: begin
                n_ok   = w_any_eq;
                n_rpos = POS_W'(w_first_eq);
            end
            OP_REMOVE_ALL: n_ok = 1'b1;
            default: n_ok = 1'b0;
        endcase
    end

    // Command and target position for the cell chain.
    always_comb begin
        w_cmd      = CC_HOLD;
        w_cell_pos = r_pos[IDX_W-1:0];
        if (r_state == S_UPDATE) begin
            unique case (r_op)
                OP_INSERT_AT, OP_SORTED_INS: begin
                    w_cell_pos = r_fpos[IDX_W-1:0];
                    if (r_ok) w_cmd = CC_SHIFT_UP;
                end
                OP_ERASE_AT: if (r_ok) w_cmd = CC_SHIFT_DOWN;
                OP_SET:      if (r_ok) w_cmd = CC_WRITE;
                default:     w_cmd = CC_HOLD;
            endcase
        end else if (r_state == S_COMPACT) begin
            w_cmd      = CC_COMPACT;
            w_cell_pos = r_wr[IDX_W-1:0];
        end
    end

    // The chain of entry cells.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            ost_cell #(
                .DATA_WIDTH(DATA_WIDTH),
                .IDX_W     (IDX_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_my_idx    (IDX_W'(g)),
                .i_pos       (w_cell_pos),
                .i_value     (r_val),
                .i_below     (w_data[(g == 0) ? 0 : g - 1]),
                .i_above     (w_data[(g == CAPACITY - 1) ? g : g + 1]),
                .i_compact   (w_scan_data),
                .i_compact_en((r_scan < r_count) && (w_scan_data != r_val)
                              && (IDX_W'(g) == r_wr[IDX_W-1:0])),
                .o_data      (w_data[g])
            );
        end
    endgenerate

    // Request sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_tvalid && m_axis_tready) r_tvalid <= 1'b0;
                    if (s_axis_tvalid) begin
                        r_op    <= t_op'(s_axis_tuser);
                        r_pos   <= s_axis_tdata[6:0];
                        r_val   <= s_axis_tdata[7 +: DATA_WIDTH];
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // The search waits until the previous result has left.
                    if (w_out_free) begin
                        r_tvalid <= 1'b0;
                        r_ok     <= n_ok;
                        r_rpos   <= n_rpos;
                        r_rval   <= n_rval;
                        r_rcnt   <= '0;
                        r_fpos   <= n_fpos;
                        r_scan   <= '0;
                        r_wr     <= '0;
                        r_state  <= (r_op == OP_REMOVE_ALL) ? S_COMPACT : S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    if (r_ok && (r_op == OP_INSERT_AT || r_op == OP_SORTED_INS))
                        r_count <= r_count + 1'b1;
                    else if (r_ok && r_op == OP_ERASE_AT)
                        r_count <= r_count - 1'b1;
                    r_tvalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_COMPACT: begin
                    if (r_scan < r_count) begin
                        if (w_scan_data != r_val) r_wr <= r_wr + 1'b1;
                        r_scan <= r_scan + 1'b1;
                    end else begin
                        r_rcnt   <= POS_W'(r_count - r_wr);
                        r_count  <= r_wr;
                        r_tvalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = {1'b0, (r_count == '0), POS_W'(r_count), r_rcnt, r_rval,
                            r_rpos, r_ok};

    `OST_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, r_tvalid,
        r_state == S_IDLE || r_state == S_SEARCH, "result valid while list is updating")
    `OST_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `OST_ASSERT_NEXT(a_search_next, i_clk, i_rst_n, r_state == S_SEARCH && w_out_free,
        r_state == S_UPDATE || r_state == S_COMPACT, "search not followed by update")
endmodule

// ===== rtl/core/ost_cell.sv =====
// One entry cell of the ordered sequence table chain.
// Depends on ost_pkg; neighbors feed it their stored values each cycle.
`timescale 1ns / 1ps

module ost_cell #(
    parameter int DATA_WIDTH = ost_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 6
) (
    input  logic                  i_clk,
    input  ost_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_W-1:0]      i_my_idx,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_below,
    input  logic [DATA_WIDTH-1:0] i_above,
    input  logic [DATA_WIDTH-1:0] i_compact,
    input  logic                  i_compact_en,
    output logic [DATA_WIDTH-1:0] o_data
);
    import ost_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Select the next content from the command and this cell's place.
    always_comb begin
        n_data = r_data;
        unique case (i_cmd)
            CC_SHIFT_UP: begin
                if (i_my_idx == i_pos) n_data = i_value;
                else if (i_my_idx > i_pos) n_data = i_below;
            end
            CC_SHIFT_DOWN: begin
                if (i_my_idx >= i_pos) n_data = i_above;
            end
            CC_WRITE: begin
                if (i_my_idx == i_pos) n_data = i_value;
            end
            CC_COMPACT: begin
                if (i_compact_en) n_data = i_compact;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule
